>>> rtl/core/imm_pkg.sv
// ----------------------------------------------------------------------------
// imm_pkg
// Shared types and constants of the integer matrix multiply block.
// ----------------------------------------------------------------------------
package imm_pkg;

    // opcodes carried on s_tuser
    localparam logic [1:0] OP_LOAD_A   = 2'd0;
    localparam logic [1:0] OP_LOAD_B   = 2'd1;
    localparam logic [1:0] OP_MULTIPLY = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_ROWS_A  = 2'd0;
    localparam logic [1:0] REG_INNER   = 2'd1;
    localparam logic [1:0] REG_COLS_B  = 2'd2;

    // fixed field widths
    localparam int IDX_W  = 3;
    localparam int ELEM_W = 32;
    localparam int DIM_W  = 4;
    localparam int TDATA_W = 40;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    // control token travelling down the cell chain
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } tok_t;

endpackage

>>> rtl/core/imm_ram.sv
// ----------------------------------------------------------------------------
// imm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module imm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                 aclk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

>>> rtl/core/imm_cell.sv
// ----------------------------------------------------------------------------
// imm_cell
// One product column: holds column j of B, multiplies the passing A element
// by B[k][j] and accumulates; forwards the A element to the next cell.
// ----------------------------------------------------------------------------
module imm_cell
    import imm_pkg::*;
#(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     wr_en,
    input  logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0] wr_addr,
    input  logic [DATA_WIDTH-1:0]                    wr_data,
    input  tok_t                                     tok_in,
    input  logic [DATA_WIDTH-1:0]                    a_in,
    input  logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0] k_in,
    output tok_t                                     tok_out,
    output logic [DATA_WIDTH-1:0]                    a_out,
    output logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0] k_out,
    output logic [DATA_WIDTH-1:0]                    sum_out
);

    logic [DATA_WIDTH-1:0] b_rd;
    tok_t                  t1_reg, t2_reg;
    logic [DATA_WIDTH-1:0] a1_reg;
    logic [DATA_WIDTH-1:0] prod_reg, prod_next;
    logic [DATA_WIDTH-1:0] acc_reg, acc_next;
    logic [DATA_WIDTH-1:0] hold_reg;
    logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0] k1_reg;

    // column store of B, addressed by row k
    imm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_DIM)) u_col_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (k_in),
        .rd_data (b_rd)
    );

    // token stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_reg <= '0;
            t2_reg <= '0;
        end else begin
            t1_reg <= tok_in;
            t2_reg <= t1_reg;
        end
    end

    // multiply and accumulate, wrapping at DATA_WIDTH
    assign prod_next = a1_reg * b_rd;
    assign acc_next  = t2_reg.first ? prod_reg : acc_reg + prod_reg;

    always_ff @(posedge aclk) begin
        a1_reg   <= a_in;
        k1_reg   <= k_in;
        prod_reg <= prod_next;
        if (t2_reg.valid) begin
            acc_reg <= acc_next;
            if (t2_reg.last) begin
                hold_reg <= acc_next;
            end
        end
    end

    assign tok_out = t1_reg;
    assign a_out   = a1_reg;
    assign k_out   = k1_reg;
    assign sum_out = hold_reg;

endmodule

>>> rtl/core/integer_matrix_multiply.sv
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// Signed integer matrix product C = A x B over a chain of column cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat per item; s_tuser is the opcode (load A, load B,
//   multiply). Loads leave s_tready high and produce nothing.
//   cfg_ channel: writes rows_a, inner_size, cols_b; always ready.
//   m_ channel: one beat per product element in row-major order, m_tlast on
//   the final element of a run.
// Sequencing: a multiply runs row by row. Each row issues
//   inner_size A elements, one per cycle, down the chain of MAX_DIM cells,
//   waits for the chain to drain, then emits cols_b beats at up to one per
//   cycle as the output slot frees; with inner_size zero a row emits zeros
//   at once. s_tready is low until the run's last beat is in the output
//   register.
// Reset: aresetn (synchronous, active low) restores the default dimensions
//   4, 3, 2 and clears control; the stores are undefined until loaded.
// Stall: a stalled m_ beat holds; the sequencer waits for the output slot.
// ----------------------------------------------------------------------------
module integer_matrix_multiply
    import imm_pkg::*;
#(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // elem_row[2:0] elem_col[5:3] elem_value[37:6]
    input  logic [1:0]         s_tuser,   // op[1:0]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // out_row[2:0] out_col[5:3] out_sum[37:6]
    output logic               m_tlast,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [DIM_W-1:0]   cfg_data
);

    localparam int KW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW  = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int CW  = $clog2(MAX_DIM + 1);
    localparam int DRN = MAX_DIM + 2;
    localparam int DW  = $clog2(DRN + 1);

    state_t state_reg, state_next;

    logic [DIM_W-1:0] rows_reg, inner_reg, cols_reg;
    logic [CW-1:0]    nr_reg, nk_reg, nc_reg;
    logic             zero_k_reg;
    logic [KW-1:0]    r_reg, k_reg, c_reg;
    logic [DW-1:0]    drn_reg;

    logic               m_valid_reg;
    logic               m_last_reg;
    logic [TDATA_W-1:0] m_data_reg;

    logic [IDX_W-1:0]      in_row, in_col;
    logic [DATA_WIDTH-1:0] in_val;
    logic                  in_acc, in_range;
    logic                  a_we;
    logic [AW-1:0]         a_wr_addr, a_rd_addr;
    logic [DATA_WIDTH-1:0] a_rd;

    tok_t                  tok0_reg;
    logic [KW-1:0]         k0_reg;
    tok_t                  tok_c [MAX_DIM+1];
    logic [DATA_WIDTH-1:0] a_c   [MAX_DIM+1];
    logic [KW-1:0]         k_c   [MAX_DIM+1];
    logic [DATA_WIDTH-1:0] sum_c [MAX_DIM];

    logic             out_slot;
    logic             k_last, c_last, r_last;
    logic [DATA_WIDTH-1:0] emit_sum;

    // clamp a dimension register to MAX_DIM
    function automatic logic [CW-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [4:0] w;
        w = {1'b0, v};
        if (w > 5'(MAX_DIM)) begin
            return CW'(MAX_DIM);
        end
        return CW'(v);
    endfunction

    // input unpack
    assign in_row   = s_tdata[2:0];
    assign in_col   = s_tdata[5:3];
    assign in_val   = DATA_WIDTH'($signed(s_tdata[37:6]));
    assign in_acc   = s_tvalid && s_tready;
    assign in_range = ({2'b00, in_row} < 5'(MAX_DIM)) && ({2'b00, in_col} < 5'(MAX_DIM));

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= 4'd4;
            inner_reg <= 4'd3;
            cols_reg  <= 4'd2;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ROWS_A: rows_reg  <= cfg_data;
                REG_INNER:  inner_reg <= cfg_data;
                REG_COLS_B: cols_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // store of A
    assign a_we      = in_acc && (s_tuser == OP_LOAD_A) && in_range;
    assign a_wr_addr = AW'(32'(in_row) * MAX_DIM + 32'(in_col));
    assign a_rd_addr = AW'(32'(r_reg) * MAX_DIM + 32'(k_reg));

    imm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_DIM * MAX_DIM)) u_a_ram (
        .aclk    (aclk),
        .wr_en   (a_we),
        .wr_addr (a_wr_addr),
        .wr_data (in_val),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd)
    );

    // head of the chain: token lines up with the registered A read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok0_reg <= '0;
        end else begin
            tok0_reg.valid <= (state_reg == ST_ISSUE);
            tok0_reg.first <= (k_reg == '0);
            tok0_reg.last  <= k_last;
        end
    end

    always_ff @(posedge aclk) begin
        k0_reg <= k_reg;
    end

    assign tok_c[0] = tok0_reg;
    assign a_c[0]   = a_rd;
    assign k_c[0]   = k0_reg;

    // chain of column cells
    for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
        logic b_we;
        assign b_we = in_acc && (s_tuser == OP_LOAD_B) && in_range &&
                      (32'(in_col) == j);
        imm_cell #(.MAX_DIM(MAX_DIM), .DATA_WIDTH(DATA_WIDTH)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .wr_en   (b_we),
            .wr_addr (KW'(in_row)),
            .wr_data (in_val),
            .tok_in  (tok_c[j]),
            .a_in    (a_c[j]),
            .k_in    (k_c[j]),
            .tok_out (tok_c[j+1]),
            .a_out   (a_c[j+1]),
            .k_out   (k_c[j+1]),
            .sum_out (sum_c[j])
        );
    end

    // sequencer
    assign out_slot = !m_valid_reg || m_tready;
    assign k_last   = (CW'(k_reg) + CW'(1)) == nk_reg;
    assign c_last   = (CW'(c_reg) + CW'(1)) == nc_reg;
    assign r_last   = (CW'(r_reg) + CW'(1)) == nr_reg;
    assign emit_sum = zero_k_reg ? '0 : sum_c[c_reg];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && (s_tuser == OP_MULTIPLY) &&
                    (clamp_dim(rows_reg) != '0) && (clamp_dim(cols_reg) != '0)) begin
                    state_next = (clamp_dim(inner_reg) == '0) ? ST_EMIT : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (k_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drn_reg == DW'(DRN)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_slot && c_last) begin
                    if (r_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = zero_k_reg ? ST_EMIT : ST_ISSUE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // loop counters
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                nr_reg     <= clamp_dim(rows_reg);
                nk_reg     <= clamp_dim(inner_reg);
                nc_reg     <= clamp_dim(cols_reg);
                zero_k_reg <= (clamp_dim(inner_reg) == '0);
                r_reg      <= '0;
                k_reg      <= '0;
                c_reg      <= '0;
            end
            ST_ISSUE: begin
                k_reg   <= k_reg + KW'(1);
                drn_reg <= '0;
            end
            ST_DRAIN: begin
                drn_reg <= drn_reg + DW'(1);
                c_reg   <= '0;
            end
            ST_EMIT: begin
                if (out_slot) begin
                    c_reg <= c_reg + KW'(1);
                    if (c_last) begin
                        c_reg <= '0;
                        k_reg <= '0;
                        r_reg <= r_reg + KW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_EMIT && out_slot) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EMIT && out_slot) begin
            m_data_reg <= {2'b00, 32'(emit_sum), 3'(c_reg), 3'(r_reg)};
            m_last_reg <= c_last && r_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

>>> rtl/core/imm_checker.sv
// ----------------------------------------------------------------------------
// imm_checker
// Port-level checks of the integer matrix multiply block, bound to the top.
// ----------------------------------------------------------------------------
module imm_checker
    import imm_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic [1:0]         s_tuser,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tlast
);

    // a stalled result beat holds its payload
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed under stall");

    // a run still has beats to go: no new item taken
    a_busy_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready in the middle of a run");

    // a non-multiply item taken with the output empty produces no beat
    a_no_beat_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser != OP_MULTIPLY) && !m_tvalid |=> !m_tvalid)
        else $error("beat produced by a non-multiply item");

    // a load never leaves the block busy
    a_load_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_LOAD_A || s_tuser == OP_LOAD_B)
        |=> s_tready)
        else $error("load item stalled the input");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
